### design/lav_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Look-at view matrix package
// Shared widths, vector and bundle types, and the signed product helper.
// ----------------------------------------------------------------------------
package lav_pkg;

    localparam int WORD_W    = 32;
    localparam int AXIS_BITS = 30;
    localparam int PROD_W    = 64;

    localparam logic signed [WORD_W-1:0] AXIS_ONE = WORD_W'(64'sd1 <<< AXIS_BITS);

    typedef logic [WORD_W-1:0]          word_t;
    typedef word_t [2:0]                vec3_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef prod_t [2:0]                prod3_t;

    typedef struct packed {
        vec3_t eye;
        vec3_t up;
    } setup_t;

    typedef struct packed {
        vec3_t eye;
        vec3_t z;
    } view_t;

    typedef struct packed {
        vec3_t eye;
        vec3_t x;
        vec3_t z;
    } frame_t;

    typedef struct packed {
        vec3_t x;
        vec3_t y;
        vec3_t z;
    } axes_t;

    // Full 32 x 32 signed product.
    function automatic prod_t smul(word_t a, word_t b);
        prod_t r;
        r = $signed(a) * $signed(b);
        return r;
    endfunction

endpackage
`default_nettype wire

### design/look_at_view_matrix_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Look-at view matrix
// Builds the right, upward and back axes (Q1.30) and the three translations
// (saturated fixed point) of a look-at view matrix from eye, target and up.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; the whole pipeline advances on one
// enable that drops only while a finished result waits and m_ready is low.
// The two square roots and the six divisions run bit per stage (31 each).
// Reset (aresetn low, synchronous) clears every valid bit; data is not reset.
module look_at_view_matrix_top
    import lav_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_eye_x,
    input  logic signed [31:0] s_eye_y,
    input  logic signed [31:0] s_eye_z,
    input  logic signed [31:0] s_target_x,
    input  logic signed [31:0] s_target_y,
    input  logic signed [31:0] s_target_z,
    input  logic signed [31:0] s_up_x,
    input  logic signed [31:0] s_up_y,
    input  logic signed [31:0] s_up_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_right_x,
    output logic signed [31:0] m_right_y,
    output logic signed [31:0] m_right_z,
    output logic signed [31:0] m_upward_x,
    output logic signed [31:0] m_upward_y,
    output logic signed [31:0] m_upward_z,
    output logic signed [31:0] m_back_x,
    output logic signed [31:0] m_back_y,
    output logic signed [31:0] m_back_z,
    output logic signed [31:0] m_shift_x,
    output logic signed [31:0] m_shift_y,
    output logic signed [31:0] m_shift_z
);

    localparam int D_W   = WORD_W + 1;
    localparam int YR_W  = AXIS_BITS + 1;
    localparam int SR_W  = WORD_W + 1;
    localparam logic [PROD_W-1:0] HALF     = PROD_W'(1) << (AXIS_BITS - 1);
    localparam logic [PROD_W-1:0] Y_LIM    = PROD_W'(1) << AXIS_BITS;
    localparam logic [PROD_W-1:0] NEG_LIM  = PROD_W'(1) << (WORD_W - 1);
    localparam logic [PROD_W-1:0] POS_LIM  = NEG_LIM - PROD_W'(1);

    logic ce;
    logic m_valid_reg;

    // Advance everything unless the output register holds an untaken result.
    assign ce      = !m_valid_reg || m_ready;
    assign s_ready = ce;

    // ---------------- Stage 1: capture request, form eye - target ----------
    logic                 v1_reg;
    vec3_t                eye1_reg, up1_reg;
    logic [2:0][D_W-1:0]  d1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            eye1_reg <= {s_eye_z, s_eye_y, s_eye_x};
            up1_reg  <= {s_up_z, s_up_y, s_up_x};
            d1_reg[0] <= {s_eye_x[31], s_eye_x} - {s_target_x[31], s_target_x};
            d1_reg[1] <= {s_eye_y[31], s_eye_y} - {s_target_y[31], s_target_y};
            d1_reg[2] <= {s_eye_z[31], s_eye_z} - {s_target_z[31], s_target_z};
        end
    end

    // ---------------- Back axis: normalize eye - target --------------------
    logic   vn1;
    vec3_t  z_n1;
    setup_t su_n1;

    lav_norm #(
        .IN_W   (D_W),
        .SIDE_W ($bits(setup_t))
    ) u_norm_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (v1_reg),
        .in_vec    (d1_reg),
        .in_side   ({eye1_reg, up1_reg}),
        .out_valid (vn1),
        .out_vec   (z_n1),
        .out_side  (su_n1)
    );

    // ---------------- cross(up, z): products, then differences -------------
    logic   vx1_reg, vx2_reg;
    prod3_t xa_reg, xb_reg, c_reg;
    view_t  vw1_reg, vw2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vx1_reg <= 1'b0;
            vx2_reg <= 1'b0;
        end else if (ce) begin
            vx1_reg <= vn1;
            vx2_reg <= vx1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            xa_reg[0] <= smul(su_n1.up[1], z_n1[2]);
            xb_reg[0] <= smul(su_n1.up[2], z_n1[1]);
            xa_reg[1] <= smul(su_n1.up[2], z_n1[0]);
            xb_reg[1] <= smul(su_n1.up[0], z_n1[2]);
            xa_reg[2] <= smul(su_n1.up[0], z_n1[1]);
            xb_reg[2] <= smul(su_n1.up[1], z_n1[0]);
            vw1_reg   <= '{eye: su_n1.eye, z: z_n1};
            for (int i = 0; i < 3; i++) begin
                c_reg[i] <= xa_reg[i] - xb_reg[i];
            end
            vw2_reg <= vw1_reg;
        end
    end

    // ---------------- Right axis: normalize cross(up, z) -------------------
    logic  vn2;
    vec3_t x_n2;
    view_t vw_n2;

    lav_norm #(
        .IN_W   (PROD_W),
        .SIDE_W ($bits(view_t))
    ) u_norm_right (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (vx2_reg),
        .in_vec    (c_reg),
        .in_side   (vw2_reg),
        .out_valid (vn2),
        .out_vec   (x_n2),
        .out_side  (vw_n2)
    );

    // ---------------- Upward axis: cross(z, x), round, clamp ---------------
    logic [4:0]             vy_reg;
    frame_t                 fr_reg [5];
    prod3_t                 ya_reg, yb_reg, yd_reg;
    logic [2:0][PROD_W-1:0] ym_reg;
    logic [2:0]             yn3_reg, yn4_reg;
    logic [2:0][YR_W-1:0]   yr_reg, yr_next;
    vec3_t                  y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vy_reg <= '0;
        end else if (ce) begin
            vy_reg <= {vy_reg[3:0], vn2};
        end
    end

    always_comb begin
        logic [PROD_W-1:0] r;
        for (int i = 0; i < 3; i++) begin
            r = (ym_reg[i] + HALF) >> AXIS_BITS;
            yr_next[i] = (r > Y_LIM) ? Y_LIM[YR_W-1:0] : r[YR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ya_reg[0] <= smul(vw_n2.z[1], x_n2[2]);
            yb_reg[0] <= smul(vw_n2.z[2], x_n2[1]);
            ya_reg[1] <= smul(vw_n2.z[2], x_n2[0]);
            yb_reg[1] <= smul(vw_n2.z[0], x_n2[2]);
            ya_reg[2] <= smul(vw_n2.z[0], x_n2[1]);
            yb_reg[2] <= smul(vw_n2.z[1], x_n2[0]);
            fr_reg[0] <= '{eye: vw_n2.eye, x: x_n2, z: vw_n2.z};
            for (int i = 0; i < 3; i++) begin
                yd_reg[i]  <= ya_reg[i] - yb_reg[i];
                ym_reg[i]  <= yd_reg[i][PROD_W-1] ? PROD_W'(0) - yd_reg[i] : yd_reg[i];
                yn3_reg[i] <= yd_reg[i][PROD_W-1];
                y_reg[i]   <= yn4_reg[i] ? WORD_W'(0) - WORD_W'(yr_reg[i])
                                         : WORD_W'(yr_reg[i]);
            end
            yr_reg  <= yr_next;
            yn4_reg <= yn3_reg;
            for (int s = 1; s < 5; s++) begin
                fr_reg[s] <= fr_reg[s-1];
            end
        end
    end

    // ---------------- Translations: -(axis . eye), round, saturate ---------
    logic [3:0]             vd_reg;
    axes_t                  ax_reg [5];
    prod3_t                 dpx_reg, dpy_reg, dpz_reg, ds_reg;
    logic [2:0][PROD_W-1:0] dm_reg;
    logic [2:0]             dn3_reg, dn4_reg;
    logic [2:0][SR_W-1:0]   dr_reg, dr_next;
    vec3_t                  sh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= '0;
        end else if (ce) begin
            vd_reg <= {vd_reg[2:0], vy_reg[4]};
        end
    end

    // Clamp the rounded magnitude: 2^31 when the result is negative, else 2^31 - 1.
    always_comb begin
        logic [PROD_W-1:0] r;
        logic [PROD_W-1:0] lim;
        for (int i = 0; i < 3; i++) begin
            r   = (dm_reg[i] + HALF) >> AXIS_BITS;
            lim = dn3_reg[i] ? NEG_LIM : POS_LIM;
            dr_next[i] = (r > lim) ? lim[SR_W-1:0] : r[SR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                dpx_reg[i] <= smul(fr_reg[4].x[i], fr_reg[4].eye[i]);
                dpy_reg[i] <= smul(y_reg[i],       fr_reg[4].eye[i]);
                dpz_reg[i] <= smul(fr_reg[4].z[i], fr_reg[4].eye[i]);
            end
            ax_reg[0] <= '{x: fr_reg[4].x, y: y_reg, z: fr_reg[4].z};
            ds_reg[0] <= dpx_reg[0] + dpx_reg[1] + dpx_reg[2];
            ds_reg[1] <= dpy_reg[0] + dpy_reg[1] + dpy_reg[2];
            ds_reg[2] <= dpz_reg[0] + dpz_reg[1] + dpz_reg[2];
            for (int i = 0; i < 3; i++) begin
                // Negated dot: the result is negative when the dot is positive.
                dm_reg[i]  <= ds_reg[i][PROD_W-1] ? PROD_W'(0) - ds_reg[i] : ds_reg[i];
                dn3_reg[i] <= !ds_reg[i][PROD_W-1];
                sh_reg[i]  <= dn4_reg[i] ? WORD_W'(SR_W'(0) - dr_reg[i])
                                         : dr_reg[i][WORD_W-1:0];
            end
            dr_reg  <= dr_next;
            dn4_reg <= dn3_reg;
            for (int s = 1; s < 5; s++) begin
                ax_reg[s] <= ax_reg[s-1];
            end
        end
    end

    // ---------------- Output register --------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            m_valid_reg <= vd_reg[3];
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_right_x  = ax_reg[4].x[0];
    assign m_right_y  = ax_reg[4].x[1];
    assign m_right_z  = ax_reg[4].x[2];
    assign m_upward_x = ax_reg[4].y[0];
    assign m_upward_y = ax_reg[4].y[1];
    assign m_upward_z = ax_reg[4].y[2];
    assign m_back_x   = ax_reg[4].z[0];
    assign m_back_y   = ax_reg[4].z[1];
    assign m_back_z   = ax_reg[4].z[2];
    assign m_shift_x  = sh_reg[0];
    assign m_shift_y  = sh_reg[1];
    assign m_shift_z  = sh_reg[2];

    // ---------------- Assertions -------------------------------------------
    // Reset empties the output.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Each component of the right axis lies within [-1, 1] in Q1.30.
    a_right_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($signed(m_right_x) <= AXIS_ONE && $signed(m_right_x) >= -AXIS_ONE
                  && $signed(m_right_y) <= AXIS_ONE && $signed(m_right_y) >= -AXIS_ONE
                  && $signed(m_right_z) <= AXIS_ONE && $signed(m_right_z) >= -AXIS_ONE))
        else $error("right axis out of Q1.30 range");

    // Eye equal to target leaves a zero back axis, so the right axis is zero.
    a_back_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_back_x == 0 && m_back_y == 0 && m_back_z == 0)
            |-> (m_right_x == 0 && m_right_y == 0 && m_right_z == 0))
        else $error("nonzero right axis from zero back axis");

    // A zero right axis gives a zero upward axis.
    a_right_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_right_x == 0 && m_right_y == 0 && m_right_z == 0)
            |-> (m_upward_x == 0 && m_upward_y == 0 && m_upward_z == 0))
        else $error("nonzero upward axis from zero right axis");

endmodule
`default_nettype wire

### design/lav_norm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined 3-vector normalizer
// Aligns the largest magnitude to [2^29, 2^30), takes a bit-per-stage square
// root of the sum of squares, divides each lane bit per stage. Output is Q1.30.
// ----------------------------------------------------------------------------
module lav_norm
    import lav_pkg::*;
#(
    parameter int IN_W   = 33,
    parameter int SIDE_W = 192
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 ce,
    input  logic                 in_valid,
    input  logic [2:0][IN_W-1:0] in_vec,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output vec3_t                out_vec,
    output logic [SIDE_W-1:0]    out_side
);

    localparam int NS     = $clog2(IN_W);
    localparam int ROOT_W = AXIS_BITS + 1;
    localparam int SQ_W   = 2 * AXIS_BITS;
    localparam int SUM_W  = 2 * ROOT_W;
    localparam int LAT    = NS + 2 * ROOT_W + 6;
    localparam int TAG_W  = SIDE_W + 3;

    typedef logic [2:0][IN_W-1:0]      mag3_t;
    typedef logic [2:0][AXIS_BITS-1:0] man3_t;
    typedef logic [2:0][ROOT_W-1:0]    rt3_t;

    // Valid bits and sideband travel together down a delay line.
    logic [LAT-1:0]   vld_reg;
    logic [TAG_W-1:0] tag_reg [LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            tag_reg[0] <= {in_side, in_vec[2][IN_W-1], in_vec[1][IN_W-1], in_vec[0][IN_W-1]};
            for (int t = 1; t < LAT; t++) begin
                tag_reg[t] <= tag_reg[t-1];
            end
        end
    end

    // Magnitudes and their maximum.
    mag3_t            a1_reg, a2_reg, a3_reg;
    logic [IN_W-1:0]  mx2_reg, m3_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                a1_reg[i] <= in_vec[i][IN_W-1] ? (~in_vec[i]) + IN_W'(1) : in_vec[i];
            end
            mx2_reg <= (a1_reg[0] > a1_reg[1]) ? a1_reg[0] : a1_reg[1];
            a2_reg  <= a1_reg;
            m3_reg  <= (mx2_reg > a2_reg[2]) ? mx2_reg : a2_reg[2];
            a3_reg  <= a2_reg;
        end
    end

    // Left-align the largest magnitude, one binary step a stage.
    mag3_t           sa_reg [NS];
    logic [IN_W-1:0] sm_reg [NS];

    for (genvar j = 0; j < NS; j++) begin : g_shift
        localparam int K = 1 << (NS - 1 - j);
        mag3_t           pa;
        logic [IN_W-1:0] pm;
        logic            hit;
        if (j == 0) begin : g_first
            assign pa = a3_reg;
            assign pm = m3_reg;
        end else begin : g_rest
            assign pa = sa_reg[j-1];
            assign pm = sm_reg[j-1];
        end
        assign hit = (pm[IN_W-1 -: K] == '0);
        always_ff @(posedge aclk) begin
            if (ce) begin
                sm_reg[j] <= hit ? (pm << K) : pm;
                for (int i = 0; i < 3; i++) begin
                    sa_reg[j][i] <= hit ? (pa[i] << K) : pa[i];
                end
            end
        end
    end

    // Squares and their sum.
    logic [2:0][SQ_W-1:0] sq_reg;
    man3_t                an_sq_reg, an_sum_reg;
    logic [SUM_W-1:0]     sum_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                an_sq_reg[i] <= sa_reg[NS-1][i][IN_W-1 -: AXIS_BITS];
                sq_reg[i]    <= SQ_W'(sa_reg[NS-1][i][IN_W-1 -: AXIS_BITS])
                              * SQ_W'(sa_reg[NS-1][i][IN_W-1 -: AXIS_BITS]);
            end
            sum_reg    <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            an_sum_reg <= an_sq_reg;
        end
    end

    // Integer square root, one result bit a stage.
    logic [ROOT_W:0]   rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [SUM_W-1:0]  rad_reg  [ROOT_W];
    man3_t             an_rt_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_root
        logic [ROOT_W:0]   prem;
        logic [ROOT_W-1:0] proot;
        logic [SUM_W-1:0]  prad;
        man3_t             pan;
        logic [ROOT_W+2:0] rs, tr, df;
        logic              take;
        if (k == 0) begin : g_first
            assign prem  = '0;
            assign proot = '0;
            assign prad  = sum_reg;
            assign pan   = an_sum_reg;
        end else begin : g_rest
            assign prem  = rem_reg[k-1];
            assign proot = root_reg[k-1];
            assign prad  = rad_reg[k-1];
            assign pan   = an_rt_reg[k-1];
        end
        assign rs   = {prem, prad[SUM_W-1 -: 2]};
        assign tr   = {1'b0, proot, 2'b01};
        assign take = (rs >= tr);
        assign df   = rs - tr;
        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[k]   <= take ? df[ROOT_W:0] : rs[ROOT_W:0];
                root_reg[k]  <= {proot[ROOT_W-2:0], take};
                rad_reg[k]   <= prad << 2;
                an_rt_reg[k] <= pan;
            end
        end
    end

    // Rounded division (a * 2^30 + n/2) / n, one quotient bit a stage.
    rt3_t              dr_reg [ROOT_W];
    rt3_t              dl_reg [ROOT_W];
    rt3_t              dq_reg [ROOT_W];
    logic [ROOT_W-1:0] dn_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_div
        rt3_t              pr, pl, pq, nr, nl, nq;
        logic [ROOT_W-1:0] pn;
        if (k == 0) begin : g_first
            assign pn = root_reg[ROOT_W-1];
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    pr[i] = ROOT_W'(an_rt_reg[ROOT_W-1][i][AXIS_BITS-1:1]);
                    pl[i] = {an_rt_reg[ROOT_W-1][i][0], pn[ROOT_W-1:1]};
                    pq[i] = '0;
                end
            end
        end else begin : g_rest
            assign pn = dn_reg[k-1];
            assign pr = dr_reg[k-1];
            assign pl = dl_reg[k-1];
            assign pq = dq_reg[k-1];
        end
        always_comb begin
            logic [ROOT_W:0] t;
            logic [ROOT_W:0] d;
            logic            ge;
            for (int i = 0; i < 3; i++) begin
                t     = {pr[i], pl[i][ROOT_W-1]};
                d     = t - {1'b0, pn};
                ge    = (t >= {1'b0, pn});
                nr[i] = ge ? d[ROOT_W-1:0] : t[ROOT_W-1:0];
                nl[i] = pl[i] << 1;
                nq[i] = {pq[i][ROOT_W-2:0], ge};
            end
        end
        always_ff @(posedge aclk) begin
            if (ce) begin
                dr_reg[k] <= nr;
                dl_reg[k] <= nl;
                dq_reg[k] <= nq;
                dn_reg[k] <= pn;
            end
        end
    end

    // Apply signs; a zero vector gives n == 0 and stays zero.
    vec3_t out_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                if (dn_reg[ROOT_W-1] == '0) begin
                    out_reg[i] <= '0;
                end else if (tag_reg[LAT-2][i]) begin
                    out_reg[i] <= WORD_W'(0) - {1'b0, dq_reg[ROOT_W-1][i]};
                end else begin
                    out_reg[i] <= {1'b0, dq_reg[ROOT_W-1][i]};
                end
            end
        end
    end

    assign out_valid = vld_reg[LAT-1];
    assign out_vec   = out_reg;
    assign out_side  = tag_reg[LAT-1][TAG_W-1:3];

endmodule
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Look-at view matrix testbench
// Drives eye/target/up requests through the valid/ready input channel with
// random gaps and random back-pressure. A bit-exact fixed-point model
// predicts the three axes and three translations of each request, and every
// result is checked field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
    import lav_pkg::*;

    typedef logic [8:0][31:0]  request_t;   // eye xyz, target xyz, up xyz
    typedef logic [11:0][31:0] view_mat_t;  // right, upward, back, shift

    localparam int AXIS_SH     = 30;
    localparam int WATCH_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 400;

    // Scoreboard: computes the expected view matrix of each accepted
    // request and checks results against them in order.
    class view_scoreboard;
        view_mat_t pending[$];
        int        mismatches;

        function longint unsigned mag(longint v);
            return (v < 0) ? longint'(-v) : longint'(v);
        endfunction

        function longint signed_of(longint unsigned m, bit neg);
            return neg ? -longint'(m) : longint'(m);
        endfunction

        // Rounding right shift, ties away from zero.
        function longint round_sh(longint v, int k);
            longint unsigned m;
            m = (mag(v) + (64'd1 << (k - 1))) >> k;
            return signed_of(m, v < 0);
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned res, bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (n >= res + bitv) begin
                    n   = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        // Scale magnitudes so the largest sits in [2^29, 2^30), then divide
        // by the truncated root with rounding.
        function void unit_vec(input longint v[3], output longint u[3]);
            longint unsigned a[3], m, sum, n, q;
            for (int i = 0; i < 3; i++) a[i] = mag(v[i]);
            m = a[0];
            if (a[1] > m) m = a[1];
            if (a[2] > m) m = a[2];
            if (m == 0) begin
                u = '{0, 0, 0};
                return;
            end
            while (m >= (64'd1 << AXIS_SH)) begin
                m = m >> 1;
                for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
            end
            while (m < (64'd1 << (AXIS_SH - 1))) begin
                m = m << 1;
                for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
            end
            sum = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
            n   = int_sqrt(sum);
            for (int i = 0; i < 3; i++) begin
                q    = ((a[i] << AXIS_SH) + (n >> 1)) / n;
                u[i] = signed_of(q, v[i] < 0);
            end
        endfunction

        function void cross3(input longint p[3], input longint q[3],
                             output longint r[3]);
            r[0] = p[1] * q[2] - p[2] * q[1];
            r[1] = p[2] * q[0] - p[0] * q[2];
            r[2] = p[0] * q[1] - p[1] * q[0];
        endfunction

        function longint translation(longint ax[3], longint eye[3]);
            longint dot;
            dot = ax[0] * eye[0] + ax[1] * eye[1] + ax[2] * eye[2];
            return clamp(round_sh(-dot, AXIS_SH), -64'sd2147483648, 64'sd2147483647);
        endfunction

        function void note_request(request_t r);
            longint eye[3], d[3], up[3], z[3], c[3], x[3], y[3];
            longint one;
            view_mat_t e;
            one = 64'sd1 << AXIS_SH;
            for (int i = 0; i < 3; i++) begin
                eye[i] = longint'($signed(r[i]));
                d[i]   = eye[i] - longint'($signed(r[3 + i]));
                up[i]  = longint'($signed(r[6 + i]));
            end
            unit_vec(d, z);
            cross3(up, z, c);
            unit_vec(c, x);
            cross3(z, x, y);
            for (int i = 0; i < 3; i++) begin
                y[i]      = clamp(round_sh(y[i], AXIS_SH), -one, one);
                e[i]      = x[i][31:0];
                e[3 + i]  = y[i][31:0];
                e[6 + i]  = z[i][31:0];
            end
            e[9]  = 32'(translation(x, eye));
            e[10] = 32'(translation(y, eye));
            e[11] = 32'(translation(z, eye));
            pending.push_back(e);
        endfunction

        function void check_result(view_mat_t got);
            view_mat_t e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            e = pending.pop_front();
            for (int i = 0; i < 12; i++) begin
                if (got[i] !== e[i]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("field %0d: expected %h, got %h", i, e[i], got[i]);
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    request_t    s_req;
    logic        m_valid;
    logic        m_ready = 1'b0;
    view_mat_t   m_mat;

    view_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles = 0;

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    look_at_view_matrix_top i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_eye_x    (s_req[0]),
        .s_eye_y    (s_req[1]),
        .s_eye_z    (s_req[2]),
        .s_target_x (s_req[3]),
        .s_target_y (s_req[4]),
        .s_target_z (s_req[5]),
        .s_up_x     (s_req[6]),
        .s_up_y     (s_req[7]),
        .s_up_z     (s_req[8]),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_right_x  (m_mat[0]),
        .m_right_y  (m_mat[1]),
        .m_right_z  (m_mat[2]),
        .m_upward_x (m_mat[3]),
        .m_upward_y (m_mat[4]),
        .m_upward_z (m_mat[5]),
        .m_back_x   (m_mat[6]),
        .m_back_y   (m_mat[7]),
        .m_back_z   (m_mat[8]),
        .m_shift_x  (m_mat[9]),
        .m_shift_y  (m_mat[10]),
        .m_shift_z  (m_mat[11])
    );

    // Monitor both channels at the rising edge; feed the scoreboard and
    // hold off the watchdog while anything moves.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_request(s_req);
            if (m_valid && m_ready) sb.check_result(m_mat);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCH_LIMIT) begin
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    // Receiver back-pressure, redrawn at every falling edge.
    always @(negedge aclk) begin
        if (aresetn) m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Maybe idle first, then present one request; stay valid until accepted.
    task automatic send_request(request_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_req   = r;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // Word with a random flavor: full range, small, or an extreme.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3:    return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
            4, 5:    return 32'($signed($urandom_range(65535)) - 32768);
            default: return $urandom;
        endcase
    endfunction

    function automatic request_t random_request();
        request_t r;
        int mode;
        for (int i = 0; i < 9; i++) r[i] = pick_word();
        mode = $urandom_range(19);
        if (mode == 0) begin
            // eye on top of target
            r[5:3] = r[2:0];
        end else if (mode == 1) begin
            // up along the view direction
            for (int i = 0; i < 3; i++) r[6 + i] = r[i] - r[3 + i];
        end else if (mode == 2) begin
            r[8:6] = '0;
        end
        return r;
    endfunction

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(negedge aclk);
    endtask

    initial begin
        request_t r;
        logic [31:0] one_q;
        sb            = new();
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_req         = '0;
        send_idle_pct = 11;
        recv_idle_pct = 58;
        one_q         = 32'h0001_0000;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: standard camera, eye on target, up along view,
        // zero up, and the extremes of every field.
        send_request({one_q, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd5 << 16,
                      32'd0, 32'd0});
        send_request({32'd0, one_q, 32'd0, 32'd0, 32'd0, 32'd0,
                      32'd7 << 16, 32'd3 << 16, 32'd2 << 16});
        send_request({32'd0, one_q, 32'd0, 32'd9, 32'd9, 32'd9, 32'd9, 32'd9, 32'd9});
        send_request({32'd0, 32'd0, one_q, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, one_q});
        send_request({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, one_q, one_q, one_q});
        send_request({{3{32'h7fff_ffff}}, {3{32'h8000_0000}}, {3{32'h7fff_ffff}}});
        send_request({{3{32'h8000_0000}}, {3{32'h7fff_ffff}}, {3{32'h8000_0000}}});
        send_request({{3{32'h8000_0000}}, {3{32'h8000_0000}}, {3{32'h7fff_ffff}}});
        send_request({32'h8000_0000, 32'h7fff_ffff, 32'd1, 32'hffff_ffff,
                      32'd0, 32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'h7fff_ffff});
        send_request({32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
        send_request({32'hffff_ffff, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0,
                      32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
        send_request({32'h7fff_0000, 32'h0100_0000, 32'h8001_0000, 32'h1000_0000,
                      32'hf000_0000, 32'h0800_0000, 32'h7fff_ffff, 32'd0, 32'd0});

        // Three random phases: sender-light idling, receiver-light idling,
        // then full rate. Drain fully between phases.
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 58;
                recv_idle_pct = 11;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < 230; n++) begin
                r = random_request();
                send_request(r);
            end
            wait_drained();
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
